// ----- design/rational_arith_unit_macros.svh -----
// Assertion macros shared by the rational arithmetic unit RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define RAU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rau_pkg.sv -----
// Package for the rational arithmetic unit: widths, codes, control word,
// status structs and the microcode program. No dependencies.
`default_nettype none

package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_W             = 33;
  localparam int DEN_W             = 32;
  localparam int CMD_W             = 2;
  localparam int STEP_W            = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV
  } cmd_t;

  // Datapath action of one microcode step.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_MUL1,
    ACT_MUL2,
    ACT_MUL3,
    ACT_FORM,
    ACT_DIV_REM,
    ACT_STEP,
    ACT_DIV_NUM,
    ACT_DIV_DEN,
    ACT_EMIT_RED,
    ACT_EMIT_RAW
  } act_t;

  // Jump condition: taken goes to target, otherwise fall through.
  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_NO_INPUT,
    J_Y_ZERO,
    J_G_ZERO,
    J_DIV_BUSY,
    J_OUT_BUSY
  } jump_t;

  typedef struct packed {
    act_t              act;
    jump_t             jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic y_zero;
    logic g_zero;
    logic div_busy;
  } dp_flags_t;

  typedef struct packed {
    logic      in_valid;
    logic      out_busy;
    dp_flags_t dp;
  } seq_status_t;

  // Program addresses.
  localparam logic [STEP_W-1:0] PC_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] PC_MUL1     = 5'd1;
  localparam logic [STEP_W-1:0] PC_MUL2     = 5'd2;
  localparam logic [STEP_W-1:0] PC_MUL3     = 5'd3;
  localparam logic [STEP_W-1:0] PC_FORM     = 5'd4;
  localparam logic [STEP_W-1:0] PC_LOOP     = 5'd5;
  localparam logic [STEP_W-1:0] PC_REM_GO   = 5'd6;
  localparam logic [STEP_W-1:0] PC_REM_WAIT = 5'd7;
  localparam logic [STEP_W-1:0] PC_REM_STEP = 5'd8;
  localparam logic [STEP_W-1:0] PC_GCD      = 5'd9;
  localparam logic [STEP_W-1:0] PC_NUM_GO   = 5'd10;
  localparam logic [STEP_W-1:0] PC_NUM_WAIT = 5'd11;
  localparam logic [STEP_W-1:0] PC_DEN_GO   = 5'd12;
  localparam logic [STEP_W-1:0] PC_DEN_WAIT = 5'd13;
  localparam logic [STEP_W-1:0] PC_RED_WAIT = 5'd14;
  localparam logic [STEP_W-1:0] PC_RED_EMIT = 5'd15;
  localparam logic [STEP_W-1:0] PC_RAW_WAIT = 5'd16;
  localparam logic [STEP_W-1:0] PC_RAW_EMIT = 5'd17;

  function automatic ctrl_t cw(input act_t a, input jump_t j, input logic [STEP_W-1:0] t);
    ctrl_t w;
    w.act    = a;
    w.jmp    = j;
    w.target = t;
    return w;
  endfunction

  // Microcode ROM.
  function automatic ctrl_t prog_word(input logic [STEP_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_IDLE:     w = cw(ACT_LOAD,     J_NO_INPUT, PC_IDLE);
      PC_MUL1:     w = cw(ACT_MUL1,     J_NEXT,     PC_IDLE);
      PC_MUL2:     w = cw(ACT_MUL2,     J_NEXT,     PC_IDLE);
      PC_MUL3:     w = cw(ACT_MUL3,     J_NEXT,     PC_IDLE);
      PC_FORM:     w = cw(ACT_FORM,     J_NEXT,     PC_IDLE);
      PC_LOOP:     w = cw(ACT_NONE,     J_Y_ZERO,   PC_GCD);
      PC_REM_GO:   w = cw(ACT_DIV_REM,  J_NEXT,     PC_IDLE);
      PC_REM_WAIT: w = cw(ACT_NONE,     J_DIV_BUSY, PC_REM_WAIT);
      PC_REM_STEP: w = cw(ACT_STEP,     J_ALWAYS,   PC_LOOP);
      PC_GCD:      w = cw(ACT_NONE,     J_G_ZERO,   PC_RAW_WAIT);
      PC_NUM_GO:   w = cw(ACT_DIV_NUM,  J_NEXT,     PC_IDLE);
      PC_NUM_WAIT: w = cw(ACT_NONE,     J_DIV_BUSY, PC_NUM_WAIT);
      PC_DEN_GO:   w = cw(ACT_DIV_DEN,  J_NEXT,     PC_IDLE);
      PC_DEN_WAIT: w = cw(ACT_NONE,     J_DIV_BUSY, PC_DEN_WAIT);
      PC_RED_WAIT: w = cw(ACT_NONE,     J_OUT_BUSY, PC_RED_WAIT);
      PC_RED_EMIT: w = cw(ACT_EMIT_RED, J_ALWAYS,   PC_IDLE);
      PC_RAW_WAIT: w = cw(ACT_NONE,     J_OUT_BUSY, PC_RAW_WAIT);
      PC_RAW_EMIT: w = cw(ACT_EMIT_RAW, J_ALWAYS,   PC_IDLE);
      default:     w = cw(ACT_NONE,     J_ALWAYS,   PC_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/rau_divider.sv -----
// Shared signed divider, truncating quotient and remainder, one bit a cycle.
// Depends on rational_arith_unit_macros.svh.
`default_nettype none
`include "rational_arith_unit_macros.svh"

module rau_divider #(
  parameter int WIDTH = 33
) (
  input  wire  logic                    clk,
  input  wire  logic                    rst_n,
  input  wire  logic                    start,
  input  wire  logic signed [WIDTH-1:0] dividend,
  input  wire  logic signed [WIDTH-1:0] divisor,
  output logic                          busy,
  output logic signed [WIDTH-1:0]       quot,
  output logic signed [WIDTH-1:0]       rem
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] dvs_r, dvs_nxt;
  logic             neg_q_r, neg_q_nxt;
  logic             neg_r_r, neg_r_nxt;

  logic [WIDTH-1:0] mag_dvd, mag_dvs;
  logic [WIDTH:0]   shifted, diff;

  assign mag_dvd = dividend[WIDTH-1] ? -dividend : dividend;
  assign mag_dvs = divisor[WIDTH-1]  ? -divisor  : divisor;
  assign shifted = {rem_r, quo_r[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = CW'(WIDTH);
      rem_nxt   = '0;
      quo_nxt   = mag_dvd;
      dvs_nxt   = mag_dvs;
      neg_q_nxt = dividend[WIDTH-1] ^ divisor[WIDTH-1];
      neg_r_nxt = dividend[WIDTH-1];
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
      if (!diff[WIDTH]) begin
        rem_nxt = diff[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  // Sign fix: quotient by xor of signs, remainder follows the dividend.
  assign busy = busy_r;
  assign quot = neg_q_r ? -quo_r : quo_r;
  assign rem  = neg_r_r ? -rem_r : rem_r;

  `RAU_ASSERT_IMPL(a_div_no_restart, start, !busy_r, "divider restarted while busy")
  `RAU_ASSERT_IMPL(a_div_nonzero, start, divisor != '0, "divider started with zero divisor")
  `RAU_ASSERT_NEXT(a_div_ends, busy_r && !start && cnt_r == CW'(1), !busy_r,
                   "divider ran past its bit count")

endmodule

`default_nettype wire

// ----- design/rau_datapath.sv -----
// Datapath: operand latches, shared multiplier, Euclid registers, divider.
// Depends on rau_pkg and rau_divider.
`default_nettype none

module rau_datapath #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire  logic                            clk,
  input  wire  logic                            rst_n,
  input  wire  rau_pkg::ctrl_t                  ctrl,
  input  wire  logic                            load,
  input  wire  logic [rau_pkg::CMD_W-1:0]       in_cmd,
  input  wire  logic signed [OPERAND_WIDTH-1:0] in_num_a,
  input  wire  logic signed [OPERAND_WIDTH-1:0] in_den_a,
  input  wire  logic signed [OPERAND_WIDTH-1:0] in_num_b,
  input  wire  logic signed [OPERAND_WIDTH-1:0] in_den_b,
  output rau_pkg::dp_flags_t                    flags,
  output logic signed [rau_pkg::NUM_W-1:0]      res_num,
  output logic signed [rau_pkg::DEN_W-1:0]      res_den,
  output logic                                  res_status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  // Sum of two products needs one more bit, capped at 64 where it wraps.
  localparam int SW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
  localparam int NW = rau_pkg::NUM_W;
  localparam int DW = rau_pkg::DEN_W;

  rau_pkg::cmd_t    cmd_r;
  logic signed [W-1:0]  a1_r, b1_r, a2_r, b2_r;
  logic signed [PW-1:0] t1_r, t2_r;
  logic signed [SW-1:0] num_r, den_r, x_r, y_r, qn_r;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] e1, e2, form_num;

  logic                 div_start, div_busy;
  logic signed [SW-1:0] div_dvd, div_dvs, div_quot, div_rem;

  // Multiplier operand select per step.
  always_comb begin
    mul_a = a1_r;
    mul_b = b2_r;
    case (ctrl.act)
      rau_pkg::ACT_MUL1: begin
        mul_a = a1_r;
        mul_b = (cmd_r == rau_pkg::CMD_MUL) ? a2_r : b2_r;
      end
      rau_pkg::ACT_MUL2: begin
        mul_a = a2_r;
        mul_b = b1_r;
      end
      rau_pkg::ACT_MUL3: begin
        mul_a = b1_r;
        mul_b = (cmd_r == rau_pkg::CMD_DIV) ? a2_r : b2_r;
      end
      default: begin
        mul_a = a1_r;
        mul_b = b2_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign e1 = SW'(t1_r);
  assign e2 = SW'(t2_r);

  always_comb begin
    case (cmd_r)
      rau_pkg::CMD_ADD: form_num = e1 + e2;
      rau_pkg::CMD_SUB: form_num = e1 - e2;
      default:          form_num = e1;
    endcase
  end

  // Divider operands: Euclid remainder, then num / g and den / g.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = den_r;
    div_dvs   = x_r;
    case (ctrl.act)
      rau_pkg::ACT_DIV_REM: begin
        div_start = 1'b1;
        div_dvd   = x_r;
        div_dvs   = y_r;
      end
      rau_pkg::ACT_DIV_NUM: begin
        div_start = 1'b1;
        div_dvd   = num_r;
        div_dvs   = x_r;
      end
      rau_pkg::ACT_DIV_DEN: begin
        div_start = 1'b1;
        div_dvd   = den_r;
        div_dvs   = x_r;
      end
      default: begin
        div_start = 1'b0;
        div_dvd   = den_r;
        div_dvs   = x_r;
      end
    endcase
  end

  rau_divider #(
    .WIDTH(SW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .busy    (div_busy),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= rau_pkg::cmd_t'(in_cmd);
      a1_r  <= in_num_a;
      b1_r  <= in_den_a;
      a2_r  <= in_num_b;
      b2_r  <= in_den_b;
    end
    case (ctrl.act)
      rau_pkg::ACT_MUL1: t1_r  <= prod;
      rau_pkg::ACT_MUL2: t2_r  <= prod;
      rau_pkg::ACT_MUL3: den_r <= SW'(prod);
      rau_pkg::ACT_FORM: begin
        num_r <= form_num;
        x_r   <= form_num;
        y_r   <= den_r;
      end
      rau_pkg::ACT_STEP: begin
        x_r <= y_r;
        y_r <= div_rem;
      end
      rau_pkg::ACT_DIV_DEN: qn_r <= div_quot;
      default: begin
      end
    endcase
  end

  assign flags.y_zero   = (y_r == '0);
  assign flags.g_zero   = (x_r == '0);
  assign flags.div_busy = div_busy;

  // Raw values on a zero gcd, else the two quotients.
  assign res_status = (ctrl.act == rau_pkg::ACT_EMIT_RAW);
  assign res_num    = res_status ? NW'(num_r) : NW'(qn_r);
  assign res_den    = res_status ? DW'(den_r) : DW'(div_quot);

endmodule

`default_nettype wire

// ----- design/rau_sequencer.sv -----
// Microcode sequencer: step counter over the program ROM with conditional jumps.
// Depends on rau_pkg.
`default_nettype none

module rau_sequencer (
  input  wire  logic                 clk,
  input  wire  logic                 rst_n,
  input  wire  rau_pkg::seq_status_t status,
  output rau_pkg::ctrl_t             ctrl
);

  localparam logic [rau_pkg::STEP_W-1:0] PC_ONE = 1;

  logic [rau_pkg::STEP_W-1:0] pc_r, pc_nxt;
  logic                       taken;

  assign ctrl = rau_pkg::prog_word(pc_r);

  always_comb begin
    case (ctrl.jmp)
      rau_pkg::J_NEXT:     taken = 1'b0;
      rau_pkg::J_ALWAYS:   taken = 1'b1;
      rau_pkg::J_NO_INPUT: taken = !status.in_valid;
      rau_pkg::J_Y_ZERO:   taken = status.dp.y_zero;
      rau_pkg::J_G_ZERO:   taken = status.dp.g_zero;
      rau_pkg::J_DIV_BUSY: taken = status.dp.div_busy;
      rau_pkg::J_OUT_BUSY: taken = status.out_busy;
      default:             taken = 1'b1;
    endcase
    pc_nxt = taken ? ctrl.target : pc_r + PC_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rau_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/rational_arith_unit.sv -----
// One transaction at a time; a zero gcd skips both final divisions. The next
// transaction is taken once the result sits in the output register. The bit-serial
// divider is S = min(2*OPERAND_WIDTH + 1, 64) bits wide (S = 33 at the default width).
// Synchronous active-low reset returns the sequencer to its idle step and empties
// the output register.
// Depends on rau_pkg, rau_sequencer, rau_datapath, rational_arith_unit_macros.svh.
`default_nettype none
`include "rational_arith_unit_macros.svh"

module rational_arith_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire  logic                            clk,
  input  wire  logic                            rst_n,
  // input channel
  input  wire  logic                            in_valid,
  output logic                                  in_stall,
  input  wire  logic [rau_pkg::CMD_W-1:0]       in_cmd,
  input  wire  logic signed [OPERAND_WIDTH-1:0] in_num_a,
  input  wire  logic signed [OPERAND_WIDTH-1:0] in_den_a,
  input  wire  logic signed [OPERAND_WIDTH-1:0] in_num_b,
  input  wire  logic signed [OPERAND_WIDTH-1:0] in_den_b,
  // result channel
  output logic                                  out_valid,
  input  wire  logic                            out_stall,
  output logic signed [rau_pkg::NUM_W-1:0]      out_res_num,
  output logic signed [rau_pkg::DEN_W-1:0]      out_res_den,
  output logic                                  out_status
);

  rau_pkg::ctrl_t      ctrl;
  rau_pkg::seq_status_t status;
  rau_pkg::dp_flags_t  flags;

  logic                               in_fire;
  logic                               emit;
  logic                               out_busy;
  logic signed [rau_pkg::NUM_W-1:0]   dp_num;
  logic signed [rau_pkg::DEN_W-1:0]   dp_den;
  logic                               dp_status;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [rau_pkg::NUM_W-1:0]   out_num_r;
  logic signed [rau_pkg::DEN_W-1:0]   out_den_r;
  logic                               out_status_r;

  // The input side is open only on the idle step of the program, which is
  // also the step that latches the operands.
  assign in_stall = (ctrl.act != rau_pkg::ACT_LOAD);
  assign in_fire  = in_valid && !in_stall;

  // The output register holds a result the consumer has not taken yet. The
  // program waits on this before its emit step, so emit always finds room.
  assign out_busy = out_valid_r && out_stall;
  assign emit     = (ctrl.act == rau_pkg::ACT_EMIT_RED) ||
                    (ctrl.act == rau_pkg::ACT_EMIT_RAW);

  assign status.in_valid = in_valid;
  assign status.out_busy = out_busy;
  assign status.dp       = flags;

  rau_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .status(status),
    .ctrl  (ctrl)
  );

  rau_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .load      (in_fire),
    .in_cmd    (in_cmd),
    .in_num_a  (in_num_a),
    .in_den_a  (in_den_a),
    .in_num_b  (in_num_b),
    .in_den_b  (in_den_b),
    .flags     (flags),
    .res_num   (dp_num),
    .res_den   (dp_den),
    .res_status(dp_status)
  );

  // Output register: set on emit, cleared once the transaction completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_num_r    <= dp_num;
      out_den_r    <= dp_den;
      out_status_r <= dp_status;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_status  = out_status_r;

  `RAU_ASSERT_IMPL(a_emit_has_room, emit, !out_busy, "result emitted over a pending one")
  `RAU_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall, "input open right after accept")
  `RAU_ASSERT_IMPL(a_raw_is_zero, out_valid_r && out_status_r,
                   out_num_r == '0 && out_den_r == '0, "unreduced result not zero over zero")

endmodule

`default_nettype wire
